[hw/rtl/audio_voice_resample_mix_core_defines.svh]
// assertion macros shared by the checker file
`ifndef AUDIO_VOICE_RESAMPLE_MIX_CORE_DEFINES_SVH
`define AUDIO_VOICE_RESAMPLE_MIX_CORE_DEFINES_SVH

// same-cycle implication under reset
`define AVRM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("avrm check failed");

// next-cycle implication under reset
`define AVRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("avrm check failed");

`endif

[hw/rtl/avrm_pkg.sv]
// shared types and constants of the resampling mixer voice
package avrm_pkg;

    localparam int RING_FRAMES = 256;
    localparam int RING_AW     = $clog2(RING_FRAMES);
    localparam int FRAC_BITS   = 12;
    localparam int POS_W       = 32 + FRAC_BITS;
    localparam int UNIT_STEP   = 1 << FRAC_BITS;
    localparam int SAMPLE_W    = 16;
    localparam int MIX_W       = 32;
    localparam int GAIN_W      = 16;
    localparam int LEN_W       = 24;
    localparam int OP_W        = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int MUL_X_W     = SAMPLE_W + 2;
    localparam int MUL_Y_W     = GAIN_W + 1;
    localparam int PROD_W      = MUL_X_W + MUL_Y_W;
    localparam int IN_DATA_W   = 2 * SAMPLE_W + 2 * MIX_W;
    localparam int OUT_DATA_W  = 2 * MIX_W;
    localparam int OUT_USER_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_EN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_LENGTH  = 3'd5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_PRODUCE = 3'd1,
        OP_PLAY    = 3'd2,
        OP_PAUSE   = 3'd3,
        OP_STOP    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        RUN_STOPPED = 2'd0,
        RUN_PLAYING = 2'd1,
        RUN_PAUSED  = 2'd2
    } run_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_EVAL,
        DP_READ_A,
        DP_LERP_L,
        DP_LERP_R,
        DP_GAIN_L,
        DP_GAIN_R,
        DP_ADD,
        DP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RDA,
        ST_RDB,
        ST_LRP,
        ST_GNL,
        ST_GNR,
        ST_ADD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            lerp;
        logic            produce_go;
    } dp_status_t;

endpackage

[hw/rtl/avrm_ctrl.sv]
// sequencer that steps one item at a time through the datapath
module avrm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  avrm_pkg::dp_status_t status,
    output avrm_pkg::dp_op_t    cmd
);
    import avrm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = DP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd        = DP_LOAD;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd = DP_EVAL;
                if (status.op == OP_PRODUCE && status.produce_go)
                    state_next = ST_RDA;
                else
                    state_next = ST_FIN;
            end
            ST_RDA:
            begin
                cmd        = DP_READ_A;
                state_next = status.lerp ? ST_RDB : ST_GNL;
            end
            ST_RDB:
            begin
                cmd        = DP_LERP_L;
                state_next = ST_LRP;
            end
            ST_LRP:
            begin
                cmd        = DP_LERP_R;
                state_next = ST_GNL;
            end
            ST_GNL:
            begin
                cmd        = DP_GAIN_L;
                state_next = ST_GNR;
            end
            ST_GNR:
            begin
                cmd        = DP_GAIN_R;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd        = DP_ADD;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd            = DP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

[hw/rtl/avrm_dp.sv]
// voice state, sample ring, shared multiplier and result register
module avrm_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  avrm_pkg::dp_op_t                       cmd,
    output avrm_pkg::dp_status_t                   status,
    input  logic [avrm_pkg::IN_DATA_W-1:0]         s_tdata,
    input  logic [avrm_pkg::OP_W-1:0]              s_tuser,
    output logic [avrm_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic [avrm_pkg::OUT_USER_W-1:0]        m_tuser,
    input  logic                                   cfg_valid,
    input  logic [avrm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [avrm_pkg::LEN_W-1:0]             cfg_data
);
    import avrm_pkg::*;

    // configuration
    logic [GAIN_W-1:0]   step_rate_reg;
    logic [GAIN_W-1:0]   left_gain_reg;
    logic [GAIN_W-1:0]   right_gain_reg;
    logic                loop_reg;
    logic                interp_reg;
    logic [LEN_W-1:0]    length_reg;

    // voice state
    logic [31:0]         fw_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [31:0]         end_reg;
    run_t                run_reg;
    logic                rewind_reg;
    logic                completed_reg;
    logic                starved_reg;
    logic                accepted_reg;

    // item payload and work registers
    logic [OP_W-1:0]     op_reg;
    logic [SAMPLE_W-1:0] smp_l_reg;
    logic [SAMPLE_W-1:0] smp_r_reg;
    logic [MIX_W-1:0]    mix_l_reg;
    logic [MIX_W-1:0]    mix_r_reg;
    logic [SAMPLE_W-1:0] a_l_reg;
    logic [SAMPLE_W-1:0] a_r_reg;
    logic [SAMPLE_W-1:0] sl_reg;
    logic [SAMPLE_W-1:0] sr_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [2*SAMPLE_W-1:0] rdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;

    logic [2*SAMPLE_W-1:0] ring_mem [RING_FRAMES];

    logic [31:0]          frame;
    logic [FRAC_BITS-1:0] frac;
    logic                 ring_full;
    logic                 end_hit;
    logic                 halt;
    logic                 lerp;
    logic [31:0]          need;
    logic                 starve;
    logic                 load_rewind;
    logic                 mem_we;
    logic                 mem_re;
    logic [RING_AW-1:0]   rd_addr;
    logic [SAMPLE_W-1:0]  rd_l;
    logic [SAMPLE_W-1:0]  rd_r;
    logic signed [MUL_X_W-1:0] mul_x;
    logic signed [MUL_Y_W-1:0] mul_y;
    logic signed [PROD_W-1:0]  prod_sh;

    assign frame       = pos_reg[POS_W-1:FRAC_BITS];
    assign frac        = pos_reg[FRAC_BITS-1:0];
    assign ring_full   = (fw_reg >= frame) && ((fw_reg - frame) >= 32'(RING_FRAMES));
    assign end_hit     = (frame >= end_reg);
    assign halt        = end_hit && !loop_reg;
    assign lerp        = interp_reg && (step_rate_reg != GAIN_W'(UNIT_STEP));
    assign need        = lerp ? (frame + 32'd1) : frame;
    assign starve      = (frame >= fw_reg) || (need >= fw_reg);
    assign load_rewind = rewind_reg && (s_tuser == OP_PUSH || s_tuser == OP_PRODUCE);

    assign status.op         = op_reg;
    assign status.lerp       = lerp;
    assign status.produce_go = (run_reg == RUN_PLAYING) && !halt && !starve;

    // ring: one write port, one registered read port
    assign mem_we  = (cmd == DP_EVAL) && (op_reg == OP_PUSH) && !ring_full;
    assign mem_re  = (cmd == DP_EVAL) || (cmd == DP_READ_A);
    assign rd_addr = (cmd == DP_EVAL) ? frame[RING_AW-1:0]
                                      : frame[RING_AW-1:0] + RING_AW'(1);
    assign rd_l    = rdata_reg[2*SAMPLE_W-1:SAMPLE_W];
    assign rd_r    = rdata_reg[SAMPLE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[fw_reg[RING_AW-1:0]] <= {smp_l_reg, smp_r_reg};
        if (mem_re)
            rdata_reg <= ring_mem[rd_addr];
    end

    // shared multiplier operands
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (cmd)
            DP_LERP_L:
            begin
                mul_x = {{(MUL_X_W-SAMPLE_W){rd_l[SAMPLE_W-1]}}, rd_l}
                      - {{(MUL_X_W-SAMPLE_W){a_l_reg[SAMPLE_W-1]}}, a_l_reg};
                mul_y = MUL_Y_W'(frac);
            end
            DP_LERP_R:
            begin
                mul_x = {{(MUL_X_W-SAMPLE_W){rd_r[SAMPLE_W-1]}}, rd_r}
                      - {{(MUL_X_W-SAMPLE_W){a_r_reg[SAMPLE_W-1]}}, a_r_reg};
                mul_y = MUL_Y_W'(frac);
            end
            DP_GAIN_L:
            begin
                mul_x = {{(MUL_X_W-SAMPLE_W){sl_reg[SAMPLE_W-1]}}, sl_reg};
                mul_y = MUL_Y_W'(left_gain_reg);
            end
            DP_GAIN_R:
            begin
                mul_x = {{(MUL_X_W-SAMPLE_W){sr_reg[SAMPLE_W-1]}}, sr_reg};
                mul_y = MUL_Y_W'(right_gain_reg);
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    // arithmetic shift gives the floor of the scaled product
    assign prod_sh = prod_reg >>> FRAC_BITS;

    // payload and work registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_x * mul_y;
        case (cmd)
            DP_LOAD:
            begin
                op_reg    <= s_tuser;
                smp_l_reg <= s_tdata[SAMPLE_W-1:0];
                smp_r_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
                mix_l_reg <= s_tdata[2*SAMPLE_W+MIX_W-1:2*SAMPLE_W];
                mix_r_reg <= s_tdata[IN_DATA_W-1:2*SAMPLE_W+MIX_W];
            end
            DP_READ_A:
            begin
                a_l_reg <= rd_l;
                a_r_reg <= rd_r;
                sl_reg  <= rd_l;
                sr_reg  <= rd_r;
            end
            DP_LERP_R:
            begin
                sl_reg <= a_l_reg + prod_sh[SAMPLE_W-1:0];
            end
            DP_GAIN_L:
            begin
                if (lerp)
                    sr_reg <= a_r_reg + prod_sh[SAMPLE_W-1:0];
            end
            DP_GAIN_R:
            begin
                mix_l_reg <= mix_l_reg + prod_sh[MIX_W-1:0];
            end
            DP_ADD:
            begin
                mix_r_reg <= mix_r_reg + prod_sh[MIX_W-1:0];
            end
            DP_EMIT:
            begin
                m_tdata_reg <= {mix_r_reg, mix_l_reg};
                m_tuser_reg <= {accepted_reg, starved_reg, completed_reg,
                                run_reg == RUN_PLAYING};
            end
            default:
            begin
            end
        endcase
    end

    // configuration and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_rate_reg  <= GAIN_W'(UNIT_STEP);
            left_gain_reg  <= GAIN_W'(UNIT_STEP);
            right_gain_reg <= GAIN_W'(UNIT_STEP);
            loop_reg       <= 1'b0;
            interp_reg     <= 1'b0;
            length_reg     <= LEN_W'(1);
            fw_reg         <= '0;
            pos_reg        <= '0;
            end_reg        <= '0;
            run_reg        <= RUN_STOPPED;
            rewind_reg     <= 1'b1;
            completed_reg  <= 1'b0;
            starved_reg    <= 1'b0;
            accepted_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_STEP_RATE:  step_rate_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_LEFT_GAIN:  left_gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_RIGHT_GAIN: right_gain_reg <= cfg_data[GAIN_W-1:0];
                    CFG_LOOP_EN:    loop_reg       <= cfg_data[0];
                    CFG_INTERP_EN:  interp_reg     <= cfg_data[0];
                    CFG_SRC_LENGTH: length_reg     <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            case (cmd)
                DP_LOAD:
                begin
                    completed_reg <= 1'b0;
                    starved_reg   <= 1'b0;
                    accepted_reg  <= 1'b0;
                    if (load_rewind)
                    begin
                        pos_reg    <= '0;
                        fw_reg     <= '0;
                        end_reg    <= 32'(length_reg);
                        rewind_reg <= 1'b0;
                    end
                end
                DP_EVAL:
                begin
                    case (op_reg)
                        OP_PUSH:
                        begin
                            if (!ring_full)
                            begin
                                fw_reg       <= fw_reg + 32'd1;
                                accepted_reg <= 1'b1;
                            end
                        end
                        OP_PRODUCE:
                        begin
                            if (run_reg == RUN_PLAYING)
                            begin
                                if (end_hit)
                                begin
                                    end_reg <= frame + 32'(length_reg);
                                    if (!loop_reg)
                                    begin
                                        run_reg       <= RUN_STOPPED;
                                        completed_reg <= 1'b1;
                                    end
                                end
                                if (!halt && starve)
                                    starved_reg <= 1'b1;
                            end
                        end
                        OP_PLAY:
                        begin
                            if (length_reg != '0)
                                run_reg <= RUN_PLAYING;
                        end
                        OP_PAUSE:
                        begin
                            run_reg <= RUN_PAUSED;
                        end
                        OP_STOP:
                        begin
                            run_reg    <= RUN_STOPPED;
                            rewind_reg <= 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                DP_ADD:
                begin
                    pos_reg <= pos_reg + POS_W'(step_rate_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

[hw/rtl/audio_voice_resample_mix_core.sv]
// top level of one resampling mixer voice
// one item at a time; the result is registered and may wait while the next item enters
// push, event and no-op produce items: load, evaluate, then finish emits the result once the output is free
// other produce items add read, lerp (if on), gain and add steps, serialized by the one shared multiplier
// and the single ring read port (two reads per interpolated frame)
// rst_n clears config to defaults, stops the voice and arms a rewind; ring contents not reset
module audio_voice_resample_mix_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [avrm_pkg::IN_DATA_W-1:0]      s_tdata,  // sample_left, sample_right, mix_left_in, mix_right_in
    input  logic [avrm_pkg::OP_W-1:0]           s_tuser,  // operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [avrm_pkg::OUT_DATA_W-1:0]     m_tdata,  // mix_left_out, mix_right_out
    output logic [avrm_pkg::OUT_USER_W-1:0]     m_tuser,  // playing, completed, starved, accepted
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [avrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [avrm_pkg::LEN_W-1:0]          cfg_data
);
    import avrm_pkg::*;

    dp_op_t     cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    avrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    avrm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

[hw/rtl/avrm_checker.sv]
// port-level checks of the mixer voice and their binding
`include "audio_voice_resample_mix_core_defines.svh"

module avrm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [avrm_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic [avrm_pkg::OUT_USER_W-1:0]     m_tuser
);
    // a stalled result stays offered
    `AVRM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // only one item is taken in before its work starts
    `AVRM_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    // a taken result is not offered again while the voice waits for input
    `AVRM_ASSERT_NEXT(a_single_result, m_tvalid && m_tready && s_tready, !m_tvalid)
    // a result never appears in the cycle right after an item is taken, unless one was already offered
    `AVRM_ASSERT_SAME(a_min_latency, $past(s_tvalid && s_tready) && !$past(m_tvalid),
                      !m_tvalid)
endmodule

bind audio_voice_resample_mix_core avrm_checker u_avrm_checker (.*);

[verif/audio_voice_resample_mix_core_test.sv]
// self-checking testbench of the resampling mixer voice: directed table, then random sessions
module audio_voice_resample_mix_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import avrm_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 30;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [MIX_W-1:0] mix_l;
        logic [MIX_W-1:0] mix_r;
        logic             playing;
        logic             completed;
        logic             starved;
        logic             accepted;
    } voice_result_t;

    typedef struct {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [LEN_W-1:0]     reg_val;
        logic [OP_W-1:0]      op;
        logic [SAMPLE_W-1:0]  sl;
        logic [SAMPLE_W-1:0]  sr;
        logic [MIX_W-1:0]     ml;
        logic [MIX_W-1:0]     mr;
        logic                 typed;
        voice_result_t        want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [LEN_W-1:0]      cfg_data = '0;

    // voice state as predicted
    logic signed [SAMPLE_W-1:0] ring_l [RING_FRAMES];
    logic signed [SAMPLE_W-1:0] ring_r [RING_FRAMES];
    logic [31:0]       frames_in = '0;
    logic [POS_W-1:0]  pos = '0;
    logic [31:0]       end_at = '0;
    run_t              run = RUN_STOPPED;
    logic              rewind_armed = 1'b1;
    logic [GAIN_W-1:0] cf_step = GAIN_W'(UNIT_STEP);
    logic [GAIN_W-1:0] cf_gain_l = GAIN_W'(UNIT_STEP);
    logic [GAIN_W-1:0] cf_gain_r = GAIN_W'(UNIT_STEP);
    logic              cf_loop = 1'b0;
    logic              cf_interp = 1'b0;
    logic [LEN_W-1:0]  cf_len = LEN_W'(1);

    voice_result_t voice_results_due [$];
    plan_row_t     directed_plan [$];
    int            failures = 0;
    int            items_sent = 0;
    int            cycles = 0;
    logic          steady = 1'b0;

    audio_voice_resample_mix_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int idle_gap();
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic void apply_rewind();
        if (rewind_armed)
        begin
            pos = '0;
            frames_in = '0;
            end_at = 32'(cf_len);
            rewind_armed = 1'b0;
        end
    endfunction

    function automatic longint blend(longint a, longint b, logic lerp, longint frac);
        if (!lerp)
            return a;
        return a + (((b - a) * frac) >>> FRAC_BITS);
    endfunction

    function automatic voice_result_t voice_step(logic [OP_W-1:0] op,
                                                 logic [SAMPLE_W-1:0] sl,
                                                 logic [SAMPLE_W-1:0] sr,
                                                 logic [MIX_W-1:0] ml,
                                                 logic [MIX_W-1:0] mr);
        voice_result_t r;
        logic [31:0]   frame;
        logic [31:0]   need;
        logic          lerp;
        logic          go;
        longint        a_l, b_l, a_r, b_r, frac, gl, gr, vl, vr, pl, pr;
        r = '0;
        r.mix_l = ml;
        r.mix_r = mr;
        case (op)
            OP_PUSH:
            begin
                apply_rewind();
                frame = pos[POS_W-1:FRAC_BITS];
                if (!(frames_in >= frame && frames_in - frame >= RING_FRAMES))
                begin
                    ring_l[frames_in[RING_AW-1:0]] = sl;
                    ring_r[frames_in[RING_AW-1:0]] = sr;
                    frames_in = frames_in + 32'd1;
                    r.accepted = 1'b1;
                end
            end
            OP_PRODUCE:
            begin
                apply_rewind();
                if (run == RUN_PLAYING)
                begin
                    frame = pos[POS_W-1:FRAC_BITS];
                    go = 1'b1;
                    if (frame >= end_at)
                    begin
                        end_at = frame + 32'(cf_len);
                        if (!cf_loop)
                        begin
                            run = RUN_STOPPED;
                            r.completed = 1'b1;
                            go = 1'b0;
                        end
                    end
                    if (go)
                    begin
                        lerp = cf_interp && (cf_step != GAIN_W'(UNIT_STEP));
                        need = lerp ? frame + 32'd1 : frame;
                        if (frame >= frames_in || need >= frames_in)
                            r.starved = 1'b1;
                        else
                        begin
                            frac = pos[FRAC_BITS-1:0];
                            a_l = ring_l[frame[RING_AW-1:0]];
                            b_l = ring_l[need[RING_AW-1:0]];
                            a_r = ring_r[frame[RING_AW-1:0]];
                            b_r = ring_r[need[RING_AW-1:0]];
                            gl = cf_gain_l;
                            gr = cf_gain_r;
                            vl = blend(a_l, b_l, lerp, frac);
                            vr = blend(a_r, b_r, lerp, frac);
                            pl = (vl * gl) >>> FRAC_BITS;
                            pr = (vr * gr) >>> FRAC_BITS;
                            r.mix_l = ml + pl[31:0];
                            r.mix_r = mr + pr[31:0];
                            pos = pos + POS_W'(cf_step);
                        end
                    end
                end
            end
            OP_PLAY:
                if (cf_len != '0)
                    run = RUN_PLAYING;
            OP_PAUSE:
                run = RUN_PAUSED;
            OP_STOP:
            begin
                run = RUN_STOPPED;
                rewind_armed = 1'b1;
            end
            default: ;
        endcase
        r.playing = (run == RUN_PLAYING);
        return r;
    endfunction

    function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
        plan_row_t row;
        row = '{default: '0};
        row.is_reg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] sl,
                                      logic [SAMPLE_W-1:0] sr, logic [MIX_W-1:0] ml,
                                      logic [MIX_W-1:0] mr);
        plan_row_t row;
        row = '{default: '0};
        row.op = op;
        row.sl = sl;
        row.sr = sr;
        row.ml = ml;
        row.mr = mr;
        directed_plan.push_back(row);
    endfunction

    // flags from the top: playing, completed, starved, accepted
    function automatic void plan_typed(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] sl,
                                       logic [SAMPLE_W-1:0] sr, logic [MIX_W-1:0] ml,
                                       logic [MIX_W-1:0] mr, logic [MIX_W-1:0] wl,
                                       logic [MIX_W-1:0] wr, logic [3:0] flags);
        plan_item(op, sl, sr, ml, mr);
        directed_plan[$].typed = 1'b1;
        directed_plan[$].want = {wl, wr, flags};
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] sl,
                             input logic [SAMPLE_W-1:0] sr, input logic [MIX_W-1:0] ml,
                             input logic [MIX_W-1:0] mr, input logic typed,
                             input voice_result_t want);
        int            gap;
        logic          ok;
        voice_result_t predicted;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {mr, ml, sr, sl};
        s_tuser <= op;
        do
        begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
        end
        while (!ok);
        predicted = voice_step(op, sl, sr, ml, mr);
        voice_results_due.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [MIX_W-1:0] draw_mix();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input logic [OP_W-1:0] op);
        send_item(op, draw_sample(), draw_sample(), draw_mix(), draw_mix(), 1'b0, '0);
    endtask

    // waits until the voice is idle, then writes one register
    task automatic write_voice_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        logic ok;
        s_tvalid <= 1'b0;
        while (voice_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_STEP_RATE:  cf_step = val[GAIN_W-1:0];
            CFG_LEFT_GAIN:  cf_gain_l = val[GAIN_W-1:0];
            CFG_RIGHT_GAIN: cf_gain_r = val[GAIN_W-1:0];
            CFG_LOOP_EN:    cf_loop = val[0];
            CFG_INTERP_EN:  cf_interp = val[0];
            CFG_SRC_LENGTH: cf_len = val;
            default: ;
        endcase
    endtask

    task automatic random_config();
        logic [LEN_W-1:0] v;
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 5))
                0: v = LEN_W'(4);
                1: v = LEN_W'(65535);
                2: v = LEN_W'(UNIT_STEP);
                3: v = LEN_W'($urandom_range(4, 65535));
                default: v = LEN_W'($urandom_range(2048, 8192));
            endcase
            write_voice_reg(CFG_STEP_RATE, v);
        end
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 3))
                0: v = '0;
                1: v = LEN_W'(65535);
                2: v = LEN_W'(UNIT_STEP);
                default: v = LEN_W'($urandom_range(0, 65535));
            endcase
            write_voice_reg(CFG_LEFT_GAIN, v);
        end
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 3))
                0: v = '0;
                1: v = LEN_W'(65535);
                2: v = LEN_W'(UNIT_STEP);
                default: v = LEN_W'($urandom_range(0, 65535));
            endcase
            write_voice_reg(CFG_RIGHT_GAIN, v);
        end
        if ($urandom_range(0, 1))
            write_voice_reg(CFG_LOOP_EN, LEN_W'($urandom_range(0, 1)));
        if ($urandom_range(0, 1))
            write_voice_reg(CFG_INTERP_EN, LEN_W'($urandom_range(0, 1)));
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 5))
                0: v = LEN_W'(1);
                1: v = 24'hff_ffff;
                2: v = LEN_W'($urandom_range(1, 8));
                3: v = LEN_W'($urandom_range(1, 400));
                4: v = LEN_W'($urandom_range(1, 24'hff_ffff));
                default: v = LEN_W'($urandom_range(20, 100));
            endcase
            write_voice_reg(CFG_SRC_LENGTH, v);
        end
    endtask

    // optionally stop, prefill, play, then produce with pushes keeping the ring fed, plus a rare pause, stop or play
    task automatic play_session();
        int steps;
        int r;
        if ($urandom_range(0, 1))
            send_random(OP_STOP);
        repeat ($urandom_range(0, 20)) send_random(OP_PUSH);
        send_random(OP_PLAY);
        steps = $urandom_range(20, 80);
        repeat (steps)
        begin
            r = $urandom_range(0, 19);
            if (r < 8 + int'(cf_step >> 13))
                send_random(OP_PUSH);
            else if (r < 18)
                send_random(OP_PRODUCE);
            else if (r == 18)
                send_random(OP_PAUSE);
            else
                send_random(($urandom_range(0, 3) == 0) ? OP_STOP : OP_PLAY);
        end
    endtask

    initial
    begin
        voice_result_t got;
        voice_result_t want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            logic hit;
            int   stall;
            stall = idle_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                hit = m_tvalid;
                if (hit)
                begin
                    got.mix_l = m_tdata[MIX_W-1:0];
                    got.mix_r = m_tdata[2*MIX_W-1:MIX_W];
                    got.playing = m_tuser[0];
                    got.completed = m_tuser[1];
                    got.starved = m_tuser[2];
                    got.accepted = m_tuser[3];
                    if (voice_results_due.size() == 0)
                    begin
                        if (failures < 10)
                            $display("unexpected result item: %p", got);
                        failures++;
                    end
                    else
                    begin
                        want = voice_results_due.pop_front();
                        if (got.mix_l !== want.mix_l || got.mix_r !== want.mix_r
                            || got.playing !== want.playing
                            || got.completed !== want.completed
                            || got.starved !== want.starved
                            || got.accepted !== want.accepted)
                        begin
                            if (failures < 10)
                                $display({"mismatch exp/got: left %h/%h right %h/%h ",
                                          "playing %b/%b completed %b/%b starved %b/%b ",
                                          "accepted %b/%b"},
                                         want.mix_l, got.mix_l, want.mix_r, got.mix_r,
                                         want.playing, got.playing,
                                         want.completed, got.completed,
                                         want.starved, got.starved,
                                         want.accepted, got.accepted);
                            failures++;
                        end
                    end
                end
                @(posedge clk);
            end
            while (!hit);
        end
    end

    initial
    begin
        int          target;
        logic [OP_W-1:0] op_code;

        // reset defaults: unit step and gains, no loop, no interpolation, length 1
        plan_typed(OP_PRODUCE, '0, '0, 32'h7fff_ffff, 32'h8000_0000,
                   32'h7fff_ffff, 32'h8000_0000, 4'b0000);
        plan_typed(OP_PUSH, 16'h7fff, 16'h8000, '0, '0, '0, '0, 4'b0001);
        plan_typed(OP_PUSH, 16'h8000, 16'h7fff, '0, '0, '0, '0, 4'b0001);
        plan_typed(OP_SPARE_5, 16'hffff, 16'hffff, 32'h1234_5678, 32'hffff_ffff,
                   32'h1234_5678, 32'hffff_ffff, 4'b0000);
        plan_typed(OP_PLAY, '0, '0, 32'h1, 32'h2, 32'h1, 32'h2, 4'b1000);
        plan_typed(OP_PRODUCE, '0, '0, '0, '0, 32'h0000_7fff, 32'hffff_8000, 4'b1000);
        // end of a non-looping voice
        plan_typed(OP_PRODUCE, '0, '0, 32'hffff_ffff, 32'h1,
                   32'hffff_ffff, 32'h1, 4'b0100);
        plan_typed(OP_PAUSE, '0, '0, '0, '0, '0, '0, 4'b0000);
        plan_typed(OP_PLAY, '0, '0, '0, '0, '0, '0, 4'b1000);
        plan_item(OP_PRODUCE, '0, '0, 32'h8000_0000, 32'h7fff_ffff);
        plan_reg(CFG_LOOP_EN, LEN_W'(1));
        plan_reg(CFG_INTERP_EN, LEN_W'(1));
        plan_reg(CFG_STEP_RATE, LEN_W'(4));
        plan_reg(CFG_LEFT_GAIN, LEN_W'(65535));
        plan_reg(CFG_RIGHT_GAIN, '0);
        plan_reg(CFG_SRC_LENGTH, 24'hff_ffff);
        plan_typed(OP_STOP, '0, '0, '0, '0, '0, '0, 4'b0000);
        plan_typed(OP_PLAY, '0, '0, '0, '0, '0, '0, 4'b1000);
        // rewound ring is empty
        plan_typed(OP_PRODUCE, '0, '0, 32'h5, 32'h6, 32'h5, 32'h6, 4'b1010);
        plan_typed(OP_PUSH, 16'h7fff, 16'h8000, '0, '0, '0, '0, 4'b1001);
        plan_typed(OP_PUSH, 16'h8000, 16'h7fff, '0, '0, '0, '0, 4'b1001);
        plan_typed(OP_PUSH, 16'h0000, 16'hffff, '0, '0, '0, '0, 4'b1001);
        plan_typed(OP_PUSH, 16'h1234, 16'hedcb, '0, '0, '0, '0, 4'b1001);
        plan_item(OP_PRODUCE, '0, '0, 32'h7fff_ffff, 32'h8000_0000);
        plan_item(OP_PRODUCE, '0, '0, '0, '0);
        // unit rate reads plainly with interpolation enabled
        plan_reg(CFG_STEP_RATE, LEN_W'(UNIT_STEP));
        plan_item(OP_PRODUCE, '0, '0, 32'h1000, 32'h2000);
        plan_reg(CFG_STEP_RATE, LEN_W'(65535));
        plan_item(OP_PRODUCE, '0, '0, '0, '0);
        plan_item(OP_PRODUCE, '0, '0, '0, '0);
        plan_typed(OP_SPARE_7, '0, '0, 32'hdead_beef, '0, 32'hdead_beef, '0, 4'b1000);
        // play is ignored with a zero length
        plan_reg(CFG_SRC_LENGTH, '0);
        plan_typed(OP_STOP, '0, '0, '0, '0, '0, '0, 4'b0000);
        plan_typed(OP_PLAY, '0, '0, '0, '0, '0, '0, 4'b0000);
        plan_reg(CFG_SRC_LENGTH, LEN_W'(1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_reg)
                write_voice_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            else
                send_item(directed_plan[i].op, directed_plan[i].sl, directed_plan[i].sr,
                          directed_plan[i].ml, directed_plan[i].mr,
                          directed_plan[i].typed, directed_plan[i].want);
        end

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            steady = ($urandom_range(0, 3) == 0);
            random_config();
            case ($urandom_range(0, 9))
                7:
                begin
                    // fill the ring to near or past its capacity
                    repeat ($urandom_range(250, 270)) send_random(OP_PUSH);
                    repeat ($urandom_range(1, 5)) send_random(OP_PRODUCE);
                end
                8, 9:
                    repeat ($urandom_range(5, 30))
                    begin
                        op_code = OP_W'($urandom_range(0, 4));
                        send_random(op_code);
                    end
                default:
                    play_session();
            endcase
        end
        s_tvalid <= 1'b0;

        while (voice_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (voice_results_due.size() != 0)
            failures++;
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/avrm_pkg.sv
hw/rtl/avrm_ctrl.sv
hw/rtl/avrm_dp.sv
hw/rtl/audio_voice_resample_mix_core.sv
hw/rtl/avrm_checker.sv
verif/audio_voice_resample_mix_core_test.sv
